// ===== src/kol_pkg.sv =====
// Package for the keyword/operator lexer: token kinds, keyword tables,
// token record type and sizing constants. No dependencies.
`default_nettype none

package kol_pkg;

    localparam int LEN_MAX  = 127;
    localparam int POS_BITS = 16;
    localparam int RUN_BITS = $clog2(LEN_MAX + 1);

    localparam int KEY_COUNT    = 6;
    localparam int KEY_IDX_BITS = 4;
    localparam int KEY_CHARS    = 1 << KEY_IDX_BITS;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [4:0] K_PROGRAM     = 5'd0;
    localparam logic [4:0] K_PROGRAM_END = 5'd1;
    localparam logic [4:0] K_IF          = 5'd2;
    localparam logic [4:0] K_LOOP        = 5'd3;
    localparam logic [4:0] K_END_IF      = 5'd4;
    localparam logic [4:0] K_LOOP_END    = 5'd5;
    localparam logic [4:0] K_ASSIGN      = 5'd6;
    localparam logic [4:0] K_PLUS        = 5'd7;
    localparam logic [4:0] K_MINUS       = 5'd8;
    localparam logic [4:0] K_MUL         = 5'd9;
    localparam logic [4:0] K_DIV         = 5'd10;
    localparam logic [4:0] K_MOD         = 5'd11;
    localparam logic [4:0] K_LPAREN      = 5'd12;
    localparam logic [4:0] K_RPAREN      = 5'd13;
    localparam logic [4:0] K_SEMI        = 5'd14;
    localparam logic [4:0] K_COLON       = 5'd15;
    localparam logic [4:0] K_EQ          = 5'd16;
    localparam logic [4:0] K_NEQ         = 5'd17;
    localparam logic [4:0] K_GT          = 5'd18;
    localparam logic [4:0] K_LT          = 5'd19;
    localparam logic [4:0] K_GTE         = 5'd20;
    localparam logic [4:0] K_LTE         = 5'd21;
    localparam logic [4:0] K_AND         = 5'd22;
    localparam logic [4:0] K_OR          = 5'd23;
    localparam logic [4:0] K_ID          = 5'd24;
    localparam logic [4:0] K_NUM         = 5'd25;
    localparam logic [4:0] K_EOF         = 5'd26;
    localparam logic [4:0] K_INVALID     = 5'd27;

    // Keyword spellings, in kind order, padded with zero bytes.
    localparam logic [0:KEY_CHARS-1][7:0] KEY_TEXT [0:KEY_COUNT-1] = '{
        {"program", {9{8'h00}}},
        {"end_", "program", {5{8'h00}}},
        {"if", {14{8'h00}}},
        {"loop", {12{8'h00}}},
        {"end_if", {10{8'h00}}},
        {"end_", "loop", {8{8'h00}}}
    };

    localparam logic [KEY_IDX_BITS-1:0] KEY_LEN [0:KEY_COUNT-1] = '{
        4'd7, 4'd11, 4'd2, 4'd4, 4'd6, 4'd8
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [6:0]  length;
        logic        last;
    } tok_t;

endpackage

`default_nettype wire

// ===== src/keyword_operator_lexer.sv =====
// Keyword/operator lexer top level: byte scanner and token output queue.
// Depends on kol_pkg for token kinds, keyword tables and the token record.
`default_nettype none

// The lexer takes one source byte per request on the text channel and ends a
// text with a request that has end_of_text set. It accepts a request in every
// cycle while its four-entry token queue holds at most two tokens, because one
// byte can close a pending token and emit another. Tokens leave the queue one
// per cycle on the token channel when not stalled, the earliest in the cycle
// after its byte, so the sustained byte rate is one per cycle unless the text
// produces tokens faster than the downstream side takes them. The end-of-file
// token carries token_last and returns the scanner to its reset state.
module keyword_operator_lexer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        text_valid,
    output logic             text_stall,
    input  wire logic [7:0]  ch,
    input  wire logic        end_of_text,
    output logic             token_valid,
    input  wire logic        token_stall,
    output logic [4:0]       token_kind,
    output logic [15:0]      token_start,
    output logic [6:0]       token_length,
    output logic             token_last
);

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_NUM     = 5'b00100,
        MODE_HOLD    = 5'b01000,
        MODE_COMMENT = 5'b10000
    } mode_t;

    localparam logic [kol_pkg::RUN_BITS-1:0] RUN_MAX = kol_pkg::RUN_BITS'(kol_pkg::LEN_MAX);
    localparam logic [kol_pkg::RUN_BITS-1:0] RUN_ONE = kol_pkg::RUN_BITS'(1);

    function automatic logic [kol_pkg::KEY_COUNT-1:0] key_next(
        input logic [kol_pkg::KEY_COUNT-1:0] cand,
        input logic [kol_pkg::RUN_BITS-1:0]  run,
        input logic [7:0]                    c
    );
        logic [kol_pkg::KEY_COUNT-1:0] r;
        r = cand;
        for (int k = 0; k < kol_pkg::KEY_COUNT; k++)
        begin
            if (run >= kol_pkg::RUN_BITS'(kol_pkg::KEY_LEN[k]))
            begin
                r[k] = 1'b0;
            end
            else if (kol_pkg::KEY_TEXT[k][run[kol_pkg::KEY_IDX_BITS-1:0]] != c)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    // Scanner state.
    mode_t                          mode_reg, mode_next;
    logic [7:0]                     held_reg, held_next;
    logic [15:0]                    begin_reg, begin_next;
    logic [kol_pkg::RUN_BITS-1:0]   run_reg, run_next;
    logic [kol_pkg::KEY_COUNT-1:0]  cand_reg, cand_next;
    logic [kol_pkg::POS_BITS-1:0]   pos_reg, pos_next;

    // Token queue.
    kol_pkg::tok_t                      fifo_mem [0:kol_pkg::FIFO_DEPTH-1];
    logic [kol_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [kol_pkg::FIFO_CNT_BITS-1:0]  count_reg;

    logic          accept, pop;
    logic [15:0]   pos16;
    logic          is_word;

    kol_pkg::tok_t flush_tok, fresh_tok, pair_tok, eof_tok;
    logic          flush_v, fresh_v;
    kol_pkg::tok_t tok_a, tok_b, push0, push1;
    logic          a_v, b_v;
    logic [1:0]    push_n;

    // Fresh-scan state results.
    mode_t                          fresh_mode;
    logic [7:0]                     fresh_held;
    logic [15:0]                    fresh_begin;
    logic [kol_pkg::RUN_BITS-1:0]   fresh_run;
    logic [kol_pkg::KEY_COUNT-1:0]  fresh_cand;

    logic [4:0]    ident_kind;
    logic [4:0]    pair_kind;
    logic          pair_hit;

    assign text_stall = (count_reg > kol_pkg::FIFO_CNT_BITS'(kol_pkg::FIFO_DEPTH - 2));
    assign accept     = text_valid && !text_stall;
    assign pop        = token_valid && !token_stall;
    assign pos16      = 16'(pos_reg);
    assign is_word    = is_alpha(ch) || is_digit(ch) || (ch == 8'h5F);

    // First keyword whose spelling is fully matched, else identifier.
    always_comb
    begin
        ident_kind = kol_pkg::K_ID;
        for (int k = kol_pkg::KEY_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && run_reg == kol_pkg::RUN_BITS'(kol_pkg::KEY_LEN[k]))
            begin
                ident_kind = 5'(k);
            end
        end
    end

    // Token released by whatever the current mode holds; a held !, & or | releases none.
    always_comb
    begin
        flush_v   = 1'b0;
        flush_tok = '{kind: kol_pkg::K_ID, start: begin_reg,
                      length: 7'(run_reg), last: 1'b0};
        case (mode_reg)
            MODE_IDENT:
            begin
                flush_v        = 1'b1;
                flush_tok.kind = ident_kind;
            end
            MODE_NUM:
            begin
                flush_v        = 1'b1;
                flush_tok.kind = kol_pkg::K_NUM;
            end
            MODE_HOLD:
            begin
                flush_tok.length = 7'd1;
                flush_v          = 1'b1;
                case (held_reg)
                    8'h3D:   flush_tok.kind = kol_pkg::K_ASSIGN;
                    8'h3E:   flush_tok.kind = kol_pkg::K_GT;
                    8'h3C:   flush_tok.kind = kol_pkg::K_LT;
                    8'h2F:   flush_tok.kind = kol_pkg::K_DIV;
                    default: flush_v = 1'b0;
                endcase
            end
            default:
            begin
                flush_v = 1'b0;
            end
        endcase
    end

    // Scan of the current byte with no token in progress.
    always_comb
    begin
        fresh_mode  = MODE_IDLE;
        fresh_held  = held_reg;
        fresh_begin = begin_reg;
        fresh_run   = run_reg;
        fresh_cand  = cand_reg;
        fresh_v     = 1'b0;
        fresh_tok   = '{kind: kol_pkg::K_INVALID, start: pos16, length: 7'd1, last: 1'b0};
        if (ch inside {8'h20, [8'h09:8'h0D]})
        begin
            fresh_v = 1'b0;
        end
        else if (is_alpha(ch) || ch == 8'h5F)
        begin
            fresh_mode  = MODE_IDENT;
            fresh_begin = pos16;
            fresh_cand  = key_next('1, '0, ch);
            fresh_run   = RUN_ONE;
        end
        else if (is_digit(ch))
        begin
            fresh_mode  = MODE_NUM;
            fresh_begin = pos16;
            fresh_run   = RUN_ONE;
        end
        else if (ch inside {8'h3D, 8'h21, 8'h3E, 8'h3C, 8'h26, 8'h7C, 8'h2F})
        begin
            fresh_mode  = MODE_HOLD;
            fresh_held  = ch;
            fresh_begin = pos16;
        end
        else
        begin
            fresh_v = 1'b1;
            case (ch)
                8'h2B:   fresh_tok.kind = kol_pkg::K_PLUS;
                8'h2D:   fresh_tok.kind = kol_pkg::K_MINUS;
                8'h2A:   fresh_tok.kind = kol_pkg::K_MUL;
                8'h25:   fresh_tok.kind = kol_pkg::K_MOD;
                8'h3B:   fresh_tok.kind = kol_pkg::K_SEMI;
                8'h3A:   fresh_tok.kind = kol_pkg::K_COLON;
                8'h28:   fresh_tok.kind = kol_pkg::K_LPAREN;
                8'h29:   fresh_tok.kind = kol_pkg::K_RPAREN;
                default: fresh_tok.kind = kol_pkg::K_INVALID;
            endcase
        end
    end

    // Two-character operators formed with the held byte.
    always_comb
    begin
        pair_hit  = 1'b1;
        pair_kind = kol_pkg::K_EQ;
        if (ch == 8'h3D && held_reg == 8'h3D)      pair_kind = kol_pkg::K_EQ;
        else if (ch == 8'h3D && held_reg == 8'h21) pair_kind = kol_pkg::K_NEQ;
        else if (ch == 8'h3D && held_reg == 8'h3E) pair_kind = kol_pkg::K_GTE;
        else if (ch == 8'h3D && held_reg == 8'h3C) pair_kind = kol_pkg::K_LTE;
        else if (ch == 8'h26 && held_reg == 8'h26) pair_kind = kol_pkg::K_AND;
        else if (ch == 8'h7C && held_reg == 8'h7C) pair_kind = kol_pkg::K_OR;
        else                                       pair_hit  = 1'b0;
        pair_tok = '{kind: pair_kind, start: begin_reg, length: 7'd2, last: 1'b0};
        eof_tok  = '{kind: kol_pkg::K_EOF, start: pos16, length: 7'd0, last: 1'b1};
    end

    // Next state and up to two tokens for the accepted byte.
    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        begin_next = begin_reg;
        run_next   = run_reg;
        cand_next  = cand_reg;
        pos_next   = pos_reg + kol_pkg::POS_BITS'(1);
        a_v        = 1'b0;
        b_v        = 1'b0;
        tok_a      = flush_tok;
        tok_b      = fresh_tok;
        if (end_of_text)
        begin
            a_v        = flush_v;
            b_v        = 1'b1;
            tok_b      = eof_tok;
            mode_next  = MODE_IDLE;
            held_next  = '0;
            begin_next = '0;
            run_next   = '0;
            cand_next  = '1;
            pos_next   = '0;
        end
        else
        begin
            // Default path: close what is pending and scan the byte afresh.
            a_v        = flush_v;
            b_v        = fresh_v;
            mode_next  = fresh_mode;
            held_next  = fresh_held;
            begin_next = fresh_begin;
            run_next   = fresh_run;
            cand_next  = fresh_cand;
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_word)
                    begin
                        a_v        = 1'b0;
                        b_v        = 1'b0;
                        mode_next  = mode_reg;
                        held_next  = held_reg;
                        begin_next = begin_reg;
                        cand_next  = key_next(cand_reg, run_reg, ch);
                        run_next   = (run_reg < RUN_MAX) ? run_reg + RUN_ONE : run_reg;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit(ch))
                    begin
                        a_v        = 1'b0;
                        b_v        = 1'b0;
                        mode_next  = mode_reg;
                        held_next  = held_reg;
                        begin_next = begin_reg;
                        cand_next  = cand_reg;
                        run_next   = (run_reg < RUN_MAX) ? run_reg + RUN_ONE : run_reg;
                    end
                end
                MODE_COMMENT:
                begin
                    a_v        = 1'b0;
                    b_v        = 1'b0;
                    mode_next  = (ch == 8'h0A) ? MODE_IDLE : MODE_COMMENT;
                    held_next  = held_reg;
                    begin_next = begin_reg;
                    run_next   = run_reg;
                    cand_next  = cand_reg;
                end
                MODE_HOLD:
                begin
                    if ((held_reg == 8'h2F && ch == 8'h2F) || pair_hit)
                    begin
                        a_v        = pair_hit;
                        b_v        = 1'b0;
                        tok_a      = pair_tok;
                        mode_next  = pair_hit ? MODE_IDLE : MODE_COMMENT;
                        held_next  = held_reg;
                        begin_next = begin_reg;
                        run_next   = run_reg;
                        cand_next  = cand_reg;
                    end
                end
                default:
                begin
                    a_v = 1'b0;
                end
            endcase
        end
        push0  = a_v ? tok_a : tok_b;
        push1  = tok_b;
        push_n = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= '0;
            begin_reg  <= '0;
            run_reg    <= '0;
            cand_reg   <= '1;
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                held_reg  <= held_next;
                begin_reg <= begin_next;
                run_reg   <= run_next;
                cand_reg  <= cand_next;
                pos_reg   <= pos_next;
            end
            wr_ptr_reg <= wr_ptr_reg + kol_pkg::FIFO_PTR_BITS'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + kol_pkg::FIFO_PTR_BITS'(1);
            end
            count_reg <= count_reg + kol_pkg::FIFO_CNT_BITS'(push_n)
                         - kol_pkg::FIFO_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + kol_pkg::FIFO_PTR_BITS'(1)] <= push1;
        end
    end

    assign token_valid  = (count_reg != '0);
    assign token_kind   = fifo_mem[rd_ptr_reg].kind;
    assign token_start  = fifo_mem[rd_ptr_reg].start;
    assign token_length = fifo_mem[rd_ptr_reg].length;
    assign token_last   = fifo_mem[rd_ptr_reg].last;

endmodule

`default_nettype wire
